>>> sv/tccw_pkg.sv
// Shared types, constants and command codes for the text console cell writer.
package tccw_pkg;

  localparam int SCREEN_CELLS = 2048;
  localparam int CELL_AW      = $clog2(SCREEN_CELLS);
  localparam int SPAN_W       = 15;

  localparam logic [SPAN_W-1:0] CELLS_SPAN = SPAN_W'(SCREEN_CELLS);
  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(SCREEN_CELLS - 1);

  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_SETX  = 3'd1;
  localparam logic [2:0] CMD_SETY  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [7:0]  CH_LF       = 8'h0a;
  localparam logic [7:0]  CH_CR       = 8'h0d;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [15:0] RESET_BLANK = 16'h0320;

  localparam logic [1:0] REG_COLUMNS    = 2'd0;
  localparam logic [1:0] REG_ROWS       = 2'd1;
  localparam logic [1:0] REG_FOREGROUND = 2'd2;
  localparam logic [1:0] REG_BACKGROUND = 2'd3;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_SETX,
    OP_SETY,
    OP_CLEAR,
    OP_READ,
    OP_BAD
  } tccw_op_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [7:0]         char_code;
    logic signed [11:0] position_value;
    logic [10:0]        cell_index;
  } tccw_item_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  cursor_x;
    logic [5:0]  cursor_y;
    logic [10:0] cursor_pos;
    logic [15:0] cell_data;
  } tccw_rsp_t;

  typedef struct packed {
    logic [7:0] columns;
    logic [5:0] rows;
    logic [3:0] foreground;
    logic [3:0] background;
  } tccw_cfg_t;

  typedef struct packed {
    tccw_op_e          op;
    logic [7:0]        char_code;
    logic [10:0]       position;
    logic [CELL_AW-1:0] cell_index;
  } tccw_op_t;

endpackage

>>> sv/tccw_front.sv
// Front end: accepts transactions, classifies them and queues them for the back end.
module tccw_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  tccw_pkg::tccw_item_t item_i,
  input  logic                busy_i,
  output logic                op_valid_o,
  output tccw_pkg::tccw_op_t  op_o,
  input  logic                op_pop_i
);

  tccw_pkg::tccw_op_t slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       take;
  tccw_pkg::tccw_op_t cls;

  // classify the command and clamp a negative position to zero
  always_comb begin
    cls.char_code  = item_i.char_code;
    cls.position   = item_i.position_value[11] ? 11'd0 : item_i.position_value[10:0];
    cls.cell_index = item_i.cell_index[tccw_pkg::CELL_AW-1:0];
    unique case (item_i.command)
      tccw_pkg::CMD_PUT:   cls.op = tccw_pkg::OP_PUT;
      tccw_pkg::CMD_SETX:  cls.op = tccw_pkg::OP_SETX;
      tccw_pkg::CMD_SETY:  cls.op = tccw_pkg::OP_SETY;
      tccw_pkg::CMD_CLEAR: cls.op = tccw_pkg::OP_CLEAR;
      tccw_pkg::CMD_READ:  cls.op = tccw_pkg::OP_READ;
      default:             cls.op = tccw_pkg::OP_BAD;
    endcase
  end

  assign full       = (cnt_q == 2'd2) || busy_i;
  assign take       = push && !full;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = slot_q[rd_q];

  always_comb begin
    wr_d  = take ? ~wr_q : wr_q;
    rd_d  = op_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, take} - {1'b0, op_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      slot_q[wr_q] <= cls;
    end
  end

endmodule

>>> sv/tccw_rsp_queue.sv
// Two-entry result queue between the back end and the result port.
module tccw_rsp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tccw_pkg::tccw_rsp_t rsp_i,
  output logic               full_o,
  output logic               empty,
  input  logic               pop,
  output tccw_pkg::tccw_rsp_t rsp_o
);

  tccw_pkg::tccw_rsp_t slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       put, take;

  assign full_o = (cnt_q == 2'd2);
  assign empty  = (cnt_q == 2'd0);
  assign put    = push_i && !full_o;
  assign take   = pop && !empty;
  assign rsp_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (put) wr_q <= ~wr_q;
      if (take) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, put} - {1'b0, take};
    end
  end

  always_ff @(posedge clk_i) begin
    if (put) begin
      slot_q[wr_q] <= rsp_i;
    end
  end

endmodule

>>> sv/tccw_back.sv
// Back end: cursor sequencer, divider, scroll and clear sweeps, and the screen store.
module tccw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tccw_pkg::tccw_cfg_t cfg_i,
  input  logic               op_valid_i,
  input  tccw_pkg::tccw_op_t  op_i,
  output logic               op_pop_o,
  output logic               busy_o,
  output logic               rsp_push_o,
  output tccw_pkg::tccw_rsp_t rsp_o,
  input  logic               rsp_full_i
);

  localparam logic [4:0] S_INIT   = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DIV    = 5'd2;
  localparam logic [4:0] S_FIXCHK = 5'd3;
  localparam logic [4:0] S_SCRSET = 5'd4;
  localparam logic [4:0] S_CPRD   = 5'd5;
  localparam logic [4:0] S_CPWR   = 5'd6;
  localparam logic [4:0] S_BLANK  = 5'd7;
  localparam logic [4:0] S_FIXEND = 5'd8;
  localparam logic [4:0] S_PADDR  = 5'd9;
  localparam logic [4:0] S_PACT   = 5'd10;
  localparam logic [4:0] S_CLEAR  = 5'd11;
  localparam logic [4:0] S_READ   = 5'd12;
  localparam logic [4:0] S_RDCAP  = 5'd13;
  localparam logic [4:0] S_POS    = 5'd14;
  localparam logic [4:0] S_DONE   = 5'd15;

  localparam int SW = tccw_pkg::SPAN_W;
  localparam int AW = tccw_pkg::CELL_AW;

  logic [4:0]  state_q, state_d;
  tccw_pkg::tccw_op_t op_q, op_d;
  logic [7:0]  col_q, col_d;
  logic [5:0]  row_q, row_d;
  logic [11:0] wy_q, wy_d;
  logic [7:0]  rem_q, rem_d;
  logic [11:0] quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [5:0]  k_q, k_d;
  logic [SW-1:0] off_q, off_d, bend_q, bend_d, a_q, a_d;
  logic        pass_q, pass_d, zero_q, zero_d, status_q, status_d;
  logic [15:0] data_q, data_d;
  logic [10:0] pos_q, pos_d;

  logic [15:0] mem_q [tccw_pkg::SCREEN_CELLS];
  logic [15:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata;

  logic [7:0]  c_eff;
  logic [5:0]  r_eff;
  logic [15:0] blank;
  logic [8:0]  trial;
  logic [12:0] ysum, kfull;
  logic [SW-1:0] cend, src, lin;
  logic [11:0] nx, ny;

  assign c_eff = (cfg_i.columns == 8'd0) ? 8'd1 : cfg_i.columns;
  assign r_eff = (cfg_i.rows == 6'd0) ? 6'd1 : cfg_i.rows;
  assign blank = {cfg_i.background, cfg_i.foreground, tccw_pkg::CH_SPACE};

  assign trial = {rem_q, quo_q[11]};
  assign ysum  = {1'b0, wy_q} + {1'b0, quo_q};
  assign kfull = ysum - {7'd0, r_eff} + 13'd1;
  assign cend  = bend_q - off_q;
  assign src   = a_q + off_q;
  assign lin   = SW'({7'd0, col_q}) + SW'(row_q * c_eff);

  assign busy_o = (state_q == S_INIT);
  assign rsp_o  = '{status: status_q, cursor_x: col_q, cursor_y: row_q,
                    cursor_pos: pos_q, cell_data: data_q};

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    col_d    = col_q;
    row_d    = row_q;
    wy_d     = wy_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    k_d      = k_q;
    off_d    = off_q;
    bend_d   = bend_q;
    a_d      = a_q;
    pass_d   = pass_q;
    zero_d   = zero_q;
    status_d = status_q;
    data_d   = data_q;
    pos_d    = pos_q;
    nx       = 12'd0;
    ny       = 12'd0;
    op_pop_o   = 1'b0;
    rsp_push_o = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = a_q[AW-1:0];
    mem_raddr = src[AW-1:0];
    mem_wdata = blank;

    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tccw_pkg::RESET_BLANK;
        a_d       = a_q + SW'(1);
        if (a_q[AW-1:0] == tccw_pkg::LAST_CELL) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          op_d     = op_i;
          pass_d   = 1'b0;
          status_d = 1'b0;
          data_d   = 16'd0;
          rem_d    = 8'd0;
          cnt_d    = 4'd0;
          a_d      = '0;
          unique case (op_i.op)
            tccw_pkg::OP_PUT: begin
              quo_d = {4'd0, col_q};
              wy_d  = {6'd0, row_q};
              state_d = S_DIV;
            end
            tccw_pkg::OP_SETX: begin
              quo_d = {1'b0, op_i.position};
              wy_d  = {6'd0, row_q};
              state_d = S_DIV;
            end
            tccw_pkg::OP_SETY: begin
              quo_d = {4'd0, col_q};
              wy_d  = {1'b0, op_i.position};
              state_d = S_DIV;
            end
            tccw_pkg::OP_CLEAR: state_d = S_CLEAR;
            tccw_pkg::OP_READ:  state_d = S_READ;
            default: begin
              status_d = 1'b1;
              state_d  = S_POS;
            end
          endcase
        end
      end
      S_DIV: begin
        // one quotient bit per cycle
        if (trial >= {1'b0, c_eff}) begin
          rem_d = 8'(trial - {1'b0, c_eff});
          quo_d = {quo_q[10:0], 1'b1};
        end else begin
          rem_d = trial[7:0];
          quo_d = {quo_q[10:0], 1'b0};
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd11) state_d = S_FIXCHK;
      end
      S_FIXCHK: begin
        col_d = rem_q;
        if (ysum >= {7'd0, r_eff}) begin
          k_d   = (kfull > {7'd0, r_eff}) ? r_eff : kfull[5:0];
          row_d = r_eff - 6'd1;
          state_d = S_SCRSET;
        end else begin
          row_d = ysum[5:0];
          state_d = S_FIXEND;
        end
      end
      S_SCRSET: begin
        off_d  = SW'(k_q * c_eff);
        bend_d = SW'(r_eff * c_eff);
        a_d    = '0;
        state_d = S_CPRD;
      end
      S_CPRD: begin
        if (a_q < cend && a_q < tccw_pkg::CELLS_SPAN) begin
          if (src < tccw_pkg::CELLS_SPAN) begin
            mem_re = 1'b1;
            zero_d = 1'b0;
          end else begin
            zero_d = 1'b1;
          end
          state_d = S_CPWR;
        end else begin
          a_d = cend;
          state_d = S_BLANK;
        end
      end
      S_CPWR: begin
        mem_we    = 1'b1;
        mem_wdata = zero_q ? 16'd0 : rdata_q;
        a_d       = a_q + SW'(1);
        state_d   = S_CPRD;
      end
      S_BLANK: begin
        if (a_q < bend_q && a_q < tccw_pkg::CELLS_SPAN) begin
          mem_we = 1'b1;
          a_d    = a_q + SW'(1);
        end else begin
          state_d = S_FIXEND;
        end
      end
      S_FIXEND: begin
        if (op_q.op == tccw_pkg::OP_PUT && !pass_q) state_d = S_PADDR;
        else state_d = S_POS;
      end
      S_PADDR: begin
        a_d = lin;
        state_d = S_PACT;
      end
      S_PACT: begin
        ny = {6'd0, row_q};
        nx = 12'd0;
        if (op_q.char_code == tccw_pkg::CH_LF) begin
          ny = {6'd0, row_q} + 12'd1;
        end else if (op_q.char_code != tccw_pkg::CH_CR) begin
          if (a_q < tccw_pkg::CELLS_SPAN) begin
            mem_we    = 1'b1;
            mem_wdata = {blank[15:8], op_q.char_code};
          end
          nx = {4'd0, col_q} + 12'd1;
        end
        pass_d = 1'b1;
        quo_d  = nx;
        wy_d   = ny;
        rem_d  = 8'd0;
        cnt_d  = 4'd0;
        state_d = S_DIV;
      end
      S_CLEAR: begin
        mem_we = 1'b1;
        a_d    = a_q + SW'(1);
        if (a_q[AW-1:0] == tccw_pkg::LAST_CELL) state_d = S_POS;
      end
      S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = op_q.cell_index;
        state_d   = S_RDCAP;
      end
      S_RDCAP: begin
        data_d  = rdata_q;
        state_d = S_POS;
      end
      S_POS: begin
        pos_d   = lin[10:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!rsp_full_i) begin
          rsp_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      col_q    <= 8'd0;
      row_q    <= 6'd0;
      a_q      <= '0;
      pass_q   <= 1'b0;
      status_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      a_q      <= a_d;
      pass_q   <= pass_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    wy_q   <= wy_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
    k_q    <= k_d;
    off_q  <= off_d;
    bend_q <= bend_d;
    zero_q <= zero_d;
    data_q <= data_d;
    pos_q  <= pos_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

endmodule

>>> sv/text_console_cell_writer_unit.sv
// Top level of the text console cell writer: configuration registers and the three parts.
//
//  channel   direction  handshake            payload
//  item      in         push / full          item_i      (tccw_item_t)
//  result    out        empty / pop          rsp_o       (tccw_rsp_t)
//  config    in         cfg_we_i, cfg_idx_i  cfg_data_i  (8 bits, low bits used)
//
// A transaction runs through the back-end sequencer; set x, set y and put char pass
// through the cursor divider, clear sweeps the store cell by cell, and a scroll copies
// the moved cells and then blanks the cells freed at the bottom of the screen.
// After reset a clearing pass fills all 2048 cells of the store with blanks; full stays
// high through it. Up to two transactions queue on each side, so either side may stall.
module text_console_cell_writer_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  tccw_pkg::tccw_item_t item_i,
  output logic                 empty,
  input  logic                 pop,
  output tccw_pkg::tccw_rsp_t  rsp_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  tccw_pkg::tccw_cfg_t cfg_q;
  logic                op_valid, op_pop, busy, rsp_push, rsp_full;
  tccw_pkg::tccw_op_t  op;
  tccw_pkg::tccw_rsp_t rsp;

  // hold the screen geometry and colours; writes must arrive only while idle, which the block does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns    <= 8'd80;
      cfg_q.rows       <= 6'd25;
      cfg_q.foreground <= 4'd3;
      cfg_q.background <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tccw_pkg::REG_COLUMNS:    cfg_q.columns    <= cfg_data_i;
        tccw_pkg::REG_ROWS:       cfg_q.rows       <= cfg_data_i[5:0];
        tccw_pkg::REG_FOREGROUND: cfg_q.foreground <= cfg_data_i[3:0];
        tccw_pkg::REG_BACKGROUND: cfg_q.background <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // classify and queue incoming transactions
  tccw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .item_i     (item_i),
    .busy_i     (busy),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  // carry out cursor moves, scrolls, clears and reads on the screen store
  tccw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .busy_o     (busy),
    .rsp_push_o (rsp_push),
    .rsp_o      (rsp),
    .rsp_full_i (rsp_full)
  );

  // buffer finished results until the consumer pops them
  tccw_rsp_queue u_rsp_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rsp_push),
    .rsp_i  (rsp),
    .full_o (rsp_full),
    .empty  (empty),
    .pop    (pop),
    .rsp_o  (rsp_o)
  );

endmodule
